>>> rtl/ersm_pkg.sv
// ============================================================================
// ersm_pkg
// Shared types, constants and functions of the Euler rotation scale matrix.
// ============================================================================
`default_nettype none
package ersm_pkg;

    localparam int ANGLE_FRAC_BITS = 6;
    localparam int VALUE_FRAC_BITS = 16;
    localparam int TRIG_STAGES     = 16;
    localparam int ZFRAC           = 24;
    localparam int XYFRAC          = 30;
    localparam int TABLE_LEN       = 24;
    localparam int NSTAGE          = (TRIG_STAGES < TABLE_LEN) ? TRIG_STAGES : TABLE_LEN;

    localparam int ZW  = 36;
    localparam int XYW = 34;
    localparam int TW  = 32;

    localparam logic signed [XYW-1:0] CORDIC_GAIN = XYW'(652032874);

    localparam int FULL    = 360 << ANGLE_FRAC_BITS;
    localparam int HALF    = 180 << ANGLE_FRAC_BITS;
    localparam int QUARTER = 90 << ANGLE_FRAC_BITS;

    typedef logic signed [ZW-1:0]  z_t;
    typedef logic signed [XYW-1:0] xy_t;
    typedef logic signed [TW-1:0]  trig_t;
    typedef logic signed [31:0]    val_t;

    typedef struct packed {
        xy_t x;
        xy_t y;
        z_t  z;
    } rot_t;

    typedef struct packed {
        logic [2:0] neg;
    } flags_t;

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        val_t width;
        val_t height;
        val_t pos_x;
        val_t pos_y;
        val_t pos_z;
    } in_word_t;

    typedef struct packed {
        val_t m00;
        val_t m10;
        val_t m20;
        val_t m01;
        val_t m11;
        val_t m21;
        val_t m02;
        val_t m12;
        val_t m22;
        val_t t_x;
        val_t t_y;
        val_t t_z;
    } out_word_t;

    function automatic z_t atan_deg(input int idx);
        logic [31:0] v;
        begin
            unique case (idx)
                0:  v = 32'd754974720;
                1:  v = 32'd445687602;
                2:  v = 32'd235489088;
                3:  v = 32'd119537938;
                4:  v = 32'd60000934;
                5:  v = 32'd30029717;
                6:  v = 32'd15018523;
                7:  v = 32'd7509720;
                8:  v = 32'd3754917;
                9:  v = 32'd1877466;
                10: v = 32'd938734;
                11: v = 32'd469367;
                12: v = 32'd234684;
                13: v = 32'd117342;
                14: v = 32'd58671;
                15: v = 32'd29335;
                16: v = 32'd14668;
                17: v = 32'd7334;
                18: v = 32'd3667;
                19: v = 32'd1833;
                20: v = 32'd917;
                21: v = 32'd458;
                22: v = 32'd229;
                23: v = 32'd115;
                default: v = 32'd0;
            endcase
            atan_deg = z_t'(v);
        end
    endfunction

    // signed product rounded to VALUE_FRAC_BITS
    function automatic logic signed [63:0] fx_round(input logic signed [63:0] p);
        begin
            fx_round = (p + (64'sd1 <<< (VALUE_FRAC_BITS - 1))) >>> VALUE_FRAC_BITS;
        end
    endfunction

    function automatic val_t sat32(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647)
                sat32 = 32'sh7fffffff;
            else if (v < -64'sd2147483648)
                sat32 = 32'sh80000000;
            else
                sat32 = v[31:0];
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/ersm_stream_if.sv
// ============================================================================
// ersm_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ============================================================================
`default_nettype none
interface ersm_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/ersm_cordic_cell.sv
// ============================================================================
// ersm_cordic_cell
// One CORDIC micro-rotation for the three angles, registered to the next cell.
// ============================================================================
`default_nettype none
module ersm_cordic_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic [4:0]        stage,
    input  wire logic              in_vld,
    input  ersm_pkg::rot_t         in_rot [3],
    input  ersm_pkg::flags_t       in_flags,
    input  ersm_pkg::in_word_t     in_word,
    output logic                   out_vld,
    output ersm_pkg::rot_t         out_rot [3],
    output ersm_pkg::flags_t       out_flags,
    output ersm_pkg::in_word_t     out_word
);
    import ersm_pkg::*;

    rot_t rot_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (!in_rot[k].z[ZW-1])
            begin
                rot_next[k].x = in_rot[k].x - (in_rot[k].y >>> stage);
                rot_next[k].y = in_rot[k].y + (in_rot[k].x >>> stage);
                rot_next[k].z = in_rot[k].z - atan_deg(int'(stage));
            end
            else
            begin
                rot_next[k].x = in_rot[k].x + (in_rot[k].y >>> stage);
                rot_next[k].y = in_rot[k].y - (in_rot[k].x >>> stage);
                rot_next[k].z = in_rot[k].z + atan_deg(int'(stage));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld <= 1'b0;
        else if (en)
            out_vld <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_rot   <= rot_next;
            out_flags <= in_flags;
            out_word  <= in_word;
        end
    end
endmodule
`default_nettype wire

>>> rtl/ersm_matrix.sv
// ============================================================================
// ersm_matrix
// Pipelined products: rotation terms, then column scaling and saturation.
// ============================================================================
`default_nettype none
module ersm_matrix (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_vld,
    input  ersm_pkg::rot_t         in_rot [3],
    input  ersm_pkg::flags_t       in_flags,
    input  ersm_pkg::in_word_t     in_word,
    output logic                   out_vld,
    output ersm_pkg::out_word_t    out_word
);
    import ersm_pkg::*;

    // sine, cosine and two-term products stay near +/-1.0
    typedef logic signed [17:0] t18_t;
    typedef logic signed [19:0] r_t;

    // stage A: sine / cosine
    logic [3:0] vld_reg;
    t18_t sx_reg, cx_reg, sy_reg, cy_reg, sz_reg, cz_reg;
    in_word_t wa_reg, wb_reg, wc_reg;
    // stage B: two-term products
    t18_t cycz_reg, sxsy_reg, sycz_reg, sxcy_reg, cysz_reg, cxsz_reg, cxcz_reg;
    t18_t sysz_reg, cxsy_reg, cxcy_reg, sz_b_reg, cz_b_reg, sx_b_reg;
    // stage C: rotation entries
    r_t r00_reg, r10_reg, r20_reg, r01_reg, r11_reg, r21_reg, r02_reg, r12_reg, r22_reg;

    t18_t s_v [3];
    t18_t c_v [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s_v[k] = t18_t'((in_rot[k].y + (xy_t'(1) <<< (XYFRAC - VALUE_FRAC_BITS - 1)))
                >>> (XYFRAC - VALUE_FRAC_BITS));
            c_v[k] = t18_t'((in_rot[k].x + (xy_t'(1) <<< (XYFRAC - VALUE_FRAC_BITS - 1)))
                >>> (XYFRAC - VALUE_FRAC_BITS));
            if (in_flags.neg[k])
                c_v[k] = -c_v[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[2:0], in_vld};
    end

    assign out_vld = vld_reg[3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg <= s_v[0]; cx_reg <= c_v[0];
            sy_reg <= s_v[1]; cy_reg <= c_v[1];
            sz_reg <= s_v[2]; cz_reg <= c_v[2];
            wa_reg <= in_word;

            cycz_reg <= t18_t'(fx_round(cy_reg * cz_reg));
            sxsy_reg <= t18_t'(fx_round(sx_reg * sy_reg));
            sycz_reg <= t18_t'(fx_round(sy_reg * cz_reg));
            sxcy_reg <= t18_t'(fx_round(sx_reg * cy_reg));
            cysz_reg <= t18_t'(fx_round(cy_reg * sz_reg));
            cxsz_reg <= t18_t'(fx_round(cx_reg * sz_reg));
            cxcz_reg <= t18_t'(fx_round(cx_reg * cz_reg));
            sysz_reg <= t18_t'(fx_round(sy_reg * sz_reg));
            cxsy_reg <= t18_t'(fx_round(cx_reg * sy_reg));
            cxcy_reg <= t18_t'(fx_round(cx_reg * cy_reg));
            sz_b_reg <= sz_reg;
            cz_b_reg <= cz_reg;
            sx_b_reg <= sx_reg;
            wb_reg   <= wa_reg;

            r00_reg <= r_t'(cycz_reg + fx_round(sxsy_reg * sz_b_reg));
            r10_reg <= r_t'(cxsz_reg);
            r20_reg <= r_t'(-sycz_reg + fx_round(sxcy_reg * sz_b_reg));
            r01_reg <= r_t'(-cysz_reg + fx_round(sxsy_reg * cz_b_reg));
            r11_reg <= r_t'(cxcz_reg);
            r21_reg <= r_t'(sysz_reg + fx_round(sxcy_reg * cz_b_reg));
            r02_reg <= r_t'(cxsy_reg);
            r12_reg <= -r_t'(sx_b_reg);
            r22_reg <= r_t'(cxcy_reg);
            wc_reg  <= wb_reg;

            out_word.m00 <= sat32(fx_round(r00_reg * wc_reg.width));
            out_word.m10 <= sat32(fx_round(r10_reg * wc_reg.width));
            out_word.m20 <= sat32(fx_round(r20_reg * wc_reg.width));
            out_word.m01 <= sat32(fx_round(r01_reg * wc_reg.height));
            out_word.m11 <= sat32(fx_round(r11_reg * wc_reg.height));
            out_word.m21 <= sat32(fx_round(r21_reg * wc_reg.height));
            out_word.m02 <= sat32(r02_reg);
            out_word.m12 <= sat32(r12_reg);
            out_word.m22 <= sat32(r22_reg);
            out_word.t_x <= wc_reg.pos_x;
            out_word.t_y <= wc_reg.pos_y;
            out_word.t_z <= wc_reg.pos_z;
        end
    end
endmodule
`default_nettype wire

>>> rtl/euler_rotation_scale_matrix.sv
// ============================================================================
// euler_rotation_scale_matrix
// Euler YXZ model matrix with column scaling, CORDIC cell chain front end.
// ============================================================================
//  channel  | dir | payload
//  in_ch    | in  | angles, width, height, position
//  out_ch   | out | nine rotation entries (six scaled), translation
//
//  One word per cycle while the output is not stalled.
//  The pipeline is the fold register, the chain of CORDIC cells and four
//  matrix stages.
//  Reset clears the valid bits of every stage; payload is not reset.
//  A stall at the output freezes the whole pipeline, bubbles included.
`default_nettype none
module euler_rotation_scale_matrix (
    input  wire logic clk,
    input  wire logic rst_n,
    ersm_stream_if.sink   in_ch,
    ersm_stream_if.source out_ch
);
    import ersm_pkg::*;

    logic   en;
    logic   vld_reg;
    rot_t   rot0_reg [3];
    flags_t fl0_reg;
    in_word_t w0_reg;

    logic     c_vld  [NSTAGE+1];
    rot_t     c_rot  [NSTAGE+1][3];
    flags_t   c_fl   [NSTAGE+1];
    in_word_t c_word [NSTAGE+1];

    logic signed [15:0] ang [3];
    rot_t   rot_next [3];
    flags_t fl_next;

    assign en = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;

    assign ang[0] = in_ch.data.angle_x;
    assign ang[1] = in_ch.data.angle_y;
    assign ang[2] = in_ch.data.angle_z;

    // fold each angle into [-90, 90]
    always_comb
    begin
        logic signed [17:0] r;
        r = '0;
        for (int k = 0; k < 3; k++)
        begin
            r = 18'(ang[k]);
            if (r >= 18'(FULL))
                r = r - 18'(FULL);
            else if (r < -18'(FULL))
                r = r + 18'(2 * FULL);
            else if (r < 0)
                r = r + 18'(FULL);
            if (r > 18'(HALF))
                r = r - 18'(FULL);
            fl_next.neg[k] = 1'b0;
            if (r > 18'(QUARTER))
            begin
                r = 18'(HALF) - r;
                fl_next.neg[k] = 1'b1;
            end
            else if (r < -18'(QUARTER))
            begin
                r = -18'(HALF) - r;
                fl_next.neg[k] = 1'b1;
            end
            rot_next[k].x = CORDIC_GAIN;
            rot_next[k].y = '0;
            rot_next[k].z = ZW'(r) <<< (ZFRAC - ANGLE_FRAC_BITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot0_reg <= rot_next;
            fl0_reg  <= fl_next;
            w0_reg   <= in_ch.data;
        end
    end

    assign c_vld[0]  = vld_reg;
    assign c_rot[0]  = rot0_reg;
    assign c_fl[0]   = fl0_reg;
    assign c_word[0] = w0_reg;

    for (genvar i = 0; i < NSTAGE; i++)
    begin : g_cell
        ersm_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .stage     (5'(i)),
            .in_vld    (c_vld[i]),
            .in_rot    (c_rot[i]),
            .in_flags  (c_fl[i]),
            .in_word   (c_word[i]),
            .out_vld   (c_vld[i+1]),
            .out_rot   (c_rot[i+1]),
            .out_flags (c_fl[i+1]),
            .out_word  (c_word[i+1])
        );
    end

    ersm_matrix u_matrix (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (c_vld[NSTAGE]),
        .in_rot   (c_rot[NSTAGE]),
        .in_flags (c_fl[NSTAGE]),
        .in_word  (c_word[NSTAGE]),
        .out_vld  (out_ch.valid),
        .out_word (out_ch.data)
    );

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("output word changed under stall");
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |-> !in_ch.ready)
        else $error("input taken while pipeline frozen");
    a_front_vld: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> vld_reg)
        else $error("accepted word lost at chain head");
endmodule
`default_nettype wire
